### hw/rtl/pgst_pkg.sv
// pgst_pkg: shared types, constants and table builder for the gain sag tracker
// no dependencies; imported by pgst_mul and pulse_gain_sag_tracker
package pgst_pkg;

   localparam int TAB_MAX = 1025;
   localparam int TAB_IDX_W = 11;
   localparam int MUL_W = 33;
   localparam logic [26:0] LOG2E_Q26 = 27'd96817625;
   localparam logic [47:0] RATE_RESET = 48'd15270994830;

   localparam logic [1:0] MODE_PULSE = 2'd0;
   localparam logic [1:0] MODE_FILL = 2'd2;

   localparam logic REG_RECOVERY_RATE = 1'b0;

   typedef logic [32:0] pow_tab_type [TAB_MAX];

   typedef enum logic [3:0] {
      ST_IDLE, ST_HI, ST_LO, ST_Y, ST_ZL, ST_ZH, ST_Z, ST_TAB, ST_IP,
      ST_FAC, ST_DEC, ST_DCAP, ST_DROP, ST_DNEW, ST_DONE
   } state_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] xx;
      logic [63:0] r;
      logic [63:0] b;
      xx = x;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (xx >= r + b) begin
            xx = xx - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-k/2^bits) in q1.32, built from repeated square roots of one half
   function automatic pow_tab_type build_pow_tab(input int bits);
      pow_tab_type tab;
      logic [63:0] r;
      logic [65:0] acc;
      r = 64'd1 << 31;
      for (int i = 0; i < 10; i++) begin
         if (i < bits) begin
            r = isqrt64(r << 32);
         end
      end
      tab[0] = 33'h1_0000_0000;
      for (int i = 1; i < TAB_MAX; i++) begin
         acc = 66'(tab[i - 1]) * 66'(r) + 66'h8000_0000;
         tab[i] = 33'(acc >> 32);
      end
      return tab;
   endfunction

endpackage

### hw/rtl/pgst_if.sv
// pgst_req_if / pgst_rsp_if: valid-ready channels of the gain sag tracker
// no dependencies
interface pgst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] event_time;
   logic [31:0] drop_fraction;
   modport source(output valid, mode, event_time, drop_fraction, input ready);
   modport sink(input valid, mode, event_time, drop_fraction, output ready);
endinterface

interface pgst_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] gain;
   logic        out_of_order;
   modport source(output valid, gain, out_of_order, input ready);
   modport sink(input valid, gain, out_of_order, output ready);
endinterface

### hw/rtl/pgst_mul.sv
// pgst_mul: shared unsigned multiplier with registered product
// depends on pgst_pkg
module pgst_mul (
   input  logic                          clock,
   input  logic [pgst_pkg::MUL_W-1:0]    mul_a,
   input  logic [pgst_pkg::MUL_W-1:0]    mul_b,
   output logic [2*pgst_pkg::MUL_W-1:0]  prod_ff
);
   import pgst_pkg::*;

   logic [2*MUL_W-1:0] prod_in;

   assign prod_in = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### hw/rtl/pulse_gain_sag_tracker.sv
// pulse_gain_sag_tracker: top level, sequencer around one shared multiplier
// depends on pgst_pkg, pgst_if (pgst_req_if, pgst_rsp_if) and pgst_mul
//
// usage
//   req_if carries one word per pulse, query or new-fill; rsp_if returns one
//   word per request word: gain (q1.31) before any drop of this pulse, and
//   an out-of-order flag. csr port writes recovery_rate (q0.48) at address 0.
// timing
//   a request word is taken only while the sequencer is idle. a pulse with a
//   pulse already held walks 14 steps through the shared 33x33 multiplier
//   (rate products, log2e scale, table interpolation, decay, drop), so the
//   result is loaded in the final step, and the next word is taken only
//   once the sequencer is back to idle. a query skips the drop (12
//   steps); new-fill and items with no pulse held take 1 to 3 steps.
// reset
//   synchronous, clears deficit, pulse time, pulse flag, the result valid flag
//   and sets recovery_rate to its default. no clearing pass is needed.
// stall
//   results sit in an output register; if it is still full when the next
//   result is ready, the sequencer waits in its final step until it drains.
module pulse_gain_sag_tracker #(
   parameter int EXP_TABLE_BITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   pgst_req_if.sink    req_if,
   pgst_rsp_if.source  rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import pgst_pkg::*;

   localparam int FRAC_BITS = 32 - EXP_TABLE_BITS;
   localparam logic [31:0] FRAC_MASK = 32'((64'd1 << FRAC_BITS) - 64'd1);
   localparam pow_tab_type POW_TAB = build_pow_tab(EXP_TABLE_BITS);

   // control state
   state_type   state_ff, state_in;
   logic [47:0] rate_ff;
   logic [31:0] deficit_ff;
   logic [31:0] last_ff;
   logic        seen_ff;
   logic        rsp_valid_ff;

   // per-word working registers
   logic [1:0]  mode_ff;
   logic [31:0] time_ff;
   logic [31:0] p_ff;
   logic [31:0] dt_ff;
   logic        ooo_ff;
   logic [55:0] hi_ff;
   logic [36:0] y_ff;
   logic        zero_ff;
   logic [58:0] m1_ff;
   logic [4:0]  n_ff;
   logic [31:0] f_ff;
   logic [32:0] t0_ff;
   logic [31:0] diff_ff;
   logic [32:0] fac_ff;
   logic [31:0] d_ff;
   logic [31:0] gain_ff;
   logic        rsp_ooo_ff;

   logic [MUL_W-1:0]   mul_a;
   logic [MUL_W-1:0]   mul_b;
   logic [2*MUL_W-1:0] prod_ff;

   logic        req_take;
   logic        rsp_free;
   logic        csr_write;
   logic [63:0] y_sum;
   logic [64:0] z_sum;
   logic [38:0] zz;
   logic [EXP_TABLE_BITS-1:0] tab_idx;
   logic [32:0] t0_rd;
   logic [32:0] t1_rd;
   logic [32:0] interp_val;
   logic [33:0] new_deficit;

   pgst_mul u_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod_ff(prod_ff)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.gain = gain_ff;
   assign rsp_if.out_of_order = rsp_ooo_ff;

   // csr port, one 48-bit register read as 64 bits
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr[3] == REG_RECOVERY_RATE);
   assign csr_prdata = (csr_paddr[3] == REG_RECOVERY_RATE) ? 64'(rate_ff) : 64'd0;

   // datapath glue around the multiplier
   assign y_sum = {hi_ff, 8'h00} + 64'(prod_ff[55:16]);
   assign z_sum = 65'(m1_ff) + {1'b0, prod_ff[31:0], 32'h0};
   assign zz = z_sum[64:26];
   assign tab_idx = f_ff[31:FRAC_BITS];
   assign t0_rd = POW_TAB[TAB_IDX_W'(tab_idx)];
   assign t1_rd = POW_TAB[TAB_IDX_W'(tab_idx) + TAB_IDX_W'(1)];
   assign interp_val = t0_ff - 33'(prod_ff >> FRAC_BITS);
   assign new_deficit = 34'(d_ff) + 34'(p_ff) - 34'(prod_ff[63:32]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_if.mode == MODE_FILL) begin
                  state_in = ST_DONE;
               end else if (!seen_ff) begin
                  state_in = (req_if.mode == MODE_PULSE) ? ST_DROP : ST_DONE;
               end else begin
                  state_in = ST_HI;
               end
            end
         end
         ST_HI:   state_in = ST_LO;
         ST_LO:   state_in = ST_Y;
         ST_Y:    state_in = ST_ZL;
         ST_ZL:   state_in = ST_ZH;
         ST_ZH:   state_in = ST_Z;
         ST_Z:    state_in = ST_TAB;
         ST_TAB:  state_in = ST_IP;
         ST_IP:   state_in = ST_FAC;
         ST_FAC:  state_in = ST_DEC;
         ST_DEC:  state_in = ST_DCAP;
         ST_DCAP: state_in = (mode_ff == MODE_PULSE) ? ST_DROP : ST_DONE;
         ST_DROP: state_in = ST_DNEW;
         ST_DNEW: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // multiplier operand select per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_HI: begin
            mul_a = MUL_W'(dt_ff);
            mul_b = MUL_W'(rate_ff[47:24]);
         end
         ST_LO: begin
            mul_a = MUL_W'(dt_ff);
            mul_b = MUL_W'(rate_ff[23:0]);
         end
         ST_ZL: begin
            mul_a = MUL_W'(y_ff[31:0]);
            mul_b = MUL_W'(LOG2E_Q26);
         end
         ST_ZH: begin
            mul_a = MUL_W'(y_ff[36:32]);
            mul_b = MUL_W'(LOG2E_Q26);
         end
         ST_IP: begin
            mul_a = MUL_W'(diff_ff);
            mul_b = MUL_W'(f_ff & FRAC_MASK);
         end
         ST_DEC: begin
            mul_a = MUL_W'(deficit_ff);
            mul_b = fac_ff;
         end
         ST_DROP: begin
            mul_a = MUL_W'(d_ff);
            mul_b = MUL_W'(p_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rate_ff <= RATE_RESET;
         deficit_ff <= 32'd0;
         last_ff <= 32'd0;
         seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            rate_ff <= csr_pwdata[47:0];
         end
         if (req_take && (req_if.mode == MODE_FILL)) begin
            deficit_ff <= 32'd0;
            last_ff <= 32'd0;
            seen_ff <= 1'b0;
         end
         if (state_ff == ST_DNEW) begin
            // saturating d + p - d*p
            deficit_ff <= (new_deficit[33:32] != 2'd0) ? 32'hFFFF_FFFF
                                                       : new_deficit[31:0];
            if (!ooo_ff) begin
               last_ff <= time_ff;
            end
            seen_ff <= 1'b1;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mode_ff <= req_if.mode;
               time_ff <= req_if.event_time;
               p_ff <= req_if.drop_fraction;
               d_ff <= 32'd0;
               // earlier time than the held pulse counts as no elapsed time
               if (seen_ff && (req_if.mode != MODE_FILL)
                   && (req_if.event_time < last_ff)) begin
                  ooo_ff <= 1'b1;
                  dt_ff <= 32'd0;
               end else begin
                  ooo_ff <= 1'b0;
                  dt_ff <= req_if.event_time - last_ff;
               end
            end
         end
         ST_LO: hi_ff <= prod_ff[55:0];
         ST_Y: begin
            zero_ff <= (hi_ff[55:48] != 8'd0) || (y_sum[63:37] != 27'd0);
            y_ff <= y_sum[36:0];
         end
         ST_ZH: m1_ff <= prod_ff[58:0];
         ST_Z: begin
            if (zz[38:37] != 2'd0) begin
               zero_ff <= 1'b1;
            end
            n_ff <= zz[36:32];
            f_ff <= zz[31:0];
         end
         ST_TAB: begin
            t0_ff <= t0_rd;
            diff_ff <= 32'(t0_rd - t1_rd);
         end
         ST_FAC: fac_ff <= zero_ff ? 33'd0 : (interp_val >> n_ff);
         ST_DCAP: d_ff <= prod_ff[63:32];
         ST_DONE: begin
            if (rsp_free) begin
               gain_ff <= 32'h8000_0000 - {1'b0, d_ff[31:1]};
               rsp_ooo_ff <= ooo_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
